>>> design/rob_pkg.sv
// shared types and constants for the in-order release reorder buffer
package rob_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int SEQ_BITS     = 4;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int QUEUE_DEPTH  = 2;
    localparam int Q_IDX_W      = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SEQ_BITS-1:0]     seq_number;
        logic [PAYLOAD_BITS-1:0] payload;
    } in_word_t;

    typedef struct packed {
        logic [SEQ_BITS-1:0]     out_seq_number;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic                    last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]        slot;
        logic [PAYLOAD_BITS-1:0] payload;
    } rob_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } back_state_t;

    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

>>> design/rob_front.sv
// front end: accepts words, maps them to a slot and queues them for the back end
module rob_front
    import rob_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_word_t   item,
    output logic       q_valid,
    output rob_entry_t q_entry,
    input  logic       q_take
);

    rob_entry_t       q_mem_reg [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               wr_en;
    logic               rd_en;
    rob_entry_t         new_entry;

    // slot index is the sequence number reduced to the buffer depth
    assign new_entry.slot    = IDX_W'(item.seq_number);
    assign new_entry.payload = item.payload;

    assign full    = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = q_mem_reg[rd_ptr_reg];
    assign wr_en   = push && !full;
    assign rd_en   = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + Q_IDX_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + Q_IDX_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

>>> design/rob_back.sv
// back end: slot store, in-order release sequencer and result register
module rob_back
    import rob_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  rob_entry_t q_entry,
    output logic       q_take,
    output logic       empty,
    input  logic       pop,
    output out_word_t  result
);

    back_state_t             state_reg, state_next;
    logic [DEPTH-1:0]        slot_full_reg, slot_full_next;
    logic [PAYLOAD_BITS-1:0] slot_payload_reg [DEPTH];
    logic [IDX_W-1:0]        head_reg, head_next;
    logic                    out_valid_reg, out_valid_next;
    out_word_t               out_word_reg;
    out_word_t               out_word_next;
    logic                    out_ready;
    logic                    out_load;
    logic [IDX_W-1:0]        head_inc;

    assign out_ready = !out_valid_reg || pop;
    assign head_inc  = next_index(head_reg);
    assign empty     = !out_valid_reg;
    assign result    = out_word_reg;

    always_comb
    begin
        state_next     = state_reg;
        slot_full_next = slot_full_reg;
        head_next      = head_reg;
        q_take         = 1'b0;
        out_load       = 1'b0;
        out_word_next.out_seq_number = SEQ_BITS'(head_reg);
        out_word_next.out_payload    = slot_payload_reg[head_reg];
        // next slot still full means the run goes on
        out_word_next.last_of_run    = !slot_full_reg[head_inc];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take                        = 1'b1;
                    slot_full_next[q_entry.slot] = 1'b1;
                    state_next                    = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!slot_full_reg[head_reg])
                begin
                    state_next = ST_IDLE;
                end
                else if (out_ready)
                begin
                    out_load                 = 1'b1;
                    slot_full_next[head_reg] = 1'b0;
                    head_next                = head_inc;
                    if (out_word_next.last_of_run)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_full_reg <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_full_reg <= slot_full_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            slot_payload_reg[q_entry.slot] <= q_entry.payload;
        end
        if (out_load)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

>>> design/in_order_release_reorder_buffer_top.sv
// top level of the in-order release reorder buffer
//
// input side is a queue: a word (sequence number, payload) is taken at a clock
// edge with push high and full low. the sequence number picks a slot, the
// payload is stored there and the slot is marked full (a full slot is simply
// overwritten). results come out of a queue: while empty is low the oldest
// released word is on result, and it goes at an edge with pop high.
// after each store the sequencer releases slots from the head pointer in
// order, one per cycle while the result register is empty or popped, until
// it meets an empty slot; the last word of that run carries last_of_run. a
// word ahead of the head releases nothing; the sequencer then finds the head
// slot empty. the first released word passes the input queue, the slot store
// and the result register before it shows on result. the back end stores a
// new word only when idle, after its run is released; a two-word input queue
// lets push continue while the sequencer drains.
// when pop stays low the single result register holds its word and the
// sequencer waits with it; the input queue fills and full goes high.
// reset clears the slot-full flags, the head pointer and both queues; the
// slot payloads need no reset since only full slots are read.
module in_order_release_reorder_buffer_top
    import rob_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_word_t  item,
    output logic      empty,
    input  logic      pop,
    output out_word_t result
);

    logic       q_valid;
    logic       q_take;
    rob_entry_t q_entry;

    // accept and map to slot
    rob_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_take  (q_take)
    );

    // store, release in order, hold result
    rob_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_take  (q_take),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // released words always walk the slots in order, wrapping at the depth
    logic [IDX_W-1:0] expect_seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_seq_reg <= '0;
        end
        else if (pop && !empty)
        begin
            expect_seq_reg <= next_index(expect_seq_reg);
        end
    end

    a_release_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty) |-> (result.out_seq_number == SEQ_BITS'(expect_seq_reg)))
        else $error("released word out of sequence order");

    a_take_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid)
        else $error("back end took a word from an empty queue");

    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !q_take) |=> full)
        else $error("input queue lost a word without a take");

endmodule
